// ===== hdl/pfde_pkg.sv =====
// Package of the planar frame buffer draw engine: field widths, command kinds,
// the result record and the color spread helper. No dependencies.
`timescale 1ns / 1ps

package pfde_pkg;

  // Field widths of the command and result transfers.
  localparam int KIND_W  = 2;
  localparam int X_W     = 10;
  localparam int Y_W     = 9;
  localparam int RW_W    = 10;
  localparam int RH_W    = 9;
  localparam int COLOR_W = 4;

  // One store word packs the four plane bytes, plane n in bits 8n+7..8n.
  localparam int PLANES = 4;
  localparam int DATA_W = 8 * PLANES;

  // Default screen geometry.
  localparam int DEF_SCREEN_WIDTH  = 720;
  localparam int DEF_SCREEN_HEIGHT = 480;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic               dropped;
  } res_t;

  // Address bits for a memory of the given depth, at least one.
  function automatic int addr_bits(input int depth);
    int bits;
    bits = $clog2(depth);
    return (bits < 1) ? 1 : bits;
  endfunction

  // Each color bit becomes a full plane byte.
  function automatic logic [DATA_W-1:0] spread_color(input logic [COLOR_W-1:0] color);
    logic [DATA_W-1:0] v;
    v = '0;
    for (int n = 0; n < PLANES; n++) begin
      v[8*n +: 8] = {8{color[n]}};
    end
    return v;
  endfunction

endpackage

// ===== hdl/pfde_if.sv =====
// Channel interfaces of the draw engine: the command channel and the result channel.
// Depends on pfde_pkg for the field widths.
`timescale 1ns / 1ps

interface pfde_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfde_pkg::KIND_W-1:0]  kind;
  logic [pfde_pkg::X_W-1:0]     pos_x;
  logic [pfde_pkg::Y_W-1:0]     pos_y;
  logic [pfde_pkg::RW_W-1:0]    rect_width;
  logic [pfde_pkg::RH_W-1:0]    rect_height;
  logic [pfde_pkg::COLOR_W-1:0] color;

  modport source (output valid, kind, pos_x, pos_y, rect_width, rect_height, color,
                  input ready);
  modport sink   (input valid, kind, pos_x, pos_y, rect_width, rect_height, color,
                  output ready);
endinterface

interface pfde_out_if;
  logic                        valid;
  logic                        ready;
  logic [pfde_pkg::COLOR_W-1:0] read_color;
  logic                        dropped;

  modport source (output valid, read_color, dropped, input ready);
  modport sink   (input valid, read_color, dropped, output ready);
endinterface

// ===== hdl/pfde_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pfde_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered: data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pfde_engine.sv =====
// Command sequencer of the draw engine: walks pixel writes, fills, clears and reads
// over the plane store. Depends on pfde_pkg and pfde_if; drives an external pfde_ram.
`timescale 1ns / 1ps

module pfde_engine #(
  parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT,
  parameter int ADDR_W        = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pfde_in_if.sink                     in_chan,
  output logic                        mem_we,
  output logic [ADDR_W-1:0]           mem_waddr,
  output logic [pfde_pkg::DATA_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [ADDR_W-1:0]           mem_raddr,
  input  logic [pfde_pkg::DATA_W-1:0] mem_rdata,
  output logic                        res_valid,
  output pfde_pkg::res_t              res,
  input  logic                        res_ready
);

  localparam int unsigned PIXEL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned DEPTH       = (PIXEL_COUNT + 7) / 8;
  // Largest linear index a fill can reach, with room for a row step past it.
  localparam int unsigned IDX_MAX     = 1024 * SCREEN_WIDTH + 2048;
  localparam int          IDX_W       = $clog2(IDX_MAX);
  localparam int          WORD_W      = IDX_W - 3;
  localparam int unsigned TAIL_BITS   = PIXEL_COUNT - 8 * (DEPTH - 1);

  localparam logic [IDX_W-1:0]  PIX_CNT   = IDX_W'(PIXEL_COUNT);
  localparam logic [IDX_W-1:0]  ROW_STEP  = IDX_W'(SCREEN_WIDTH);
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  // Pixels of the last word that still lie inside the store.
  localparam logic [7:0]        TAIL_MASK = 8'(16'hFF00 >> TAIL_BITS);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_FILL_RD   = 7'b0000010,
    S_FILL_WR   = 7'b0000100,
    S_CLEAR     = 7'b0001000,
    S_READ_RD   = 7'b0010000,
    S_READ_DATA = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic [IDX_W-1:0]                row_base_r, row_base_nxt;
  logic [pfde_pkg::RW_W-1:0]       rem_x_r, rem_x_nxt;
  logic [pfde_pkg::RH_W-1:0]       rem_y_r, rem_y_nxt;
  logic [pfde_pkg::RW_W-1:0]       rw_r, rw_nxt;
  logic [pfde_pkg::DATA_W-1:0]     fill_r, fill_nxt;
  logic [7:0]                      mask_r, mask_nxt;
  logic [ADDR_W-1:0]               waddr_r, waddr_nxt;
  logic                            last_r, last_nxt;
  logic                            drop_r, drop_nxt;
  pfde_pkg::res_t                  res_r, res_nxt;

  // Run of pixels in the current word.
  logic [WORD_W-1:0]               word_c;
  logic [2:0]                      off_c;
  logic [3:0]                      room_c;
  logic [3:0]                      run_c;
  logic [3:0]                      run_end_c;
  logic [7:0]                      run_mask_c;
  logic [7:0]                      valid_mask_c;
  logic                            row_end_c;
  logic                            beyond_c;
  logic [IDX_W-1:0]                next_row_c;
  logic [pfde_pkg::DATA_W-1:0]     plane_mask_c;
  logic [pfde_pkg::COLOR_W-1:0]    rd_color_c;
  logic [pfde_pkg::COLOR_W-1:0]    res_color_c;
  logic                            finish_c;
  logic                            res_drop_c;
  logic                            in_take_c;

  assign word_c     = idx_r[IDX_W-1:3];
  assign off_c      = idx_r[2:0];
  assign room_c     = 4'd8 - {1'b0, off_c};
  assign row_end_c  = (rem_x_r <= pfde_pkg::RW_W'(room_c));
  assign run_c      = row_end_c ? rem_x_r[3:0] : room_c;
  assign run_end_c  = {1'b0, off_c} + run_c;
  assign run_mask_c = 8'(16'h00FF >> off_c) & ~8'(16'h00FF >> run_end_c);
  assign beyond_c   = (idx_r >= PIX_CNT);
  assign next_row_c = row_base_r + ROW_STEP;

  // Pixels of the current word that lie inside the store.
  always_comb begin
    if (word_c < LAST_WORD) begin
      valid_mask_c = 8'hFF;
    end else if (word_c == LAST_WORD) begin
      valid_mask_c = TAIL_MASK;
    end else begin
      valid_mask_c = 8'h00;
    end
  end

  // Merge of the stored word with the fill color under the pixel mask.
  assign plane_mask_c = {pfde_pkg::PLANES{mask_r}};

  // Color of the addressed pixel, gathered from the four plane bytes.
  always_comb begin
    for (int n = 0; n < pfde_pkg::PLANES; n++) begin
      rd_color_c[n] = mem_rdata[8*n + 7 - int'(off_c)];
    end
  end

  assign in_take_c     = in_chan.valid && (state_r == S_IDLE);
  assign in_chan.ready = (state_r == S_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    row_base_nxt = row_base_r;
    rem_x_nxt    = rem_x_r;
    rem_y_nxt    = rem_y_r;
    rw_nxt       = rw_r;
    fill_nxt     = fill_r;
    mask_nxt     = mask_r;
    waddr_nxt    = waddr_r;
    last_nxt     = last_r;
    drop_nxt     = drop_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = waddr_r;
    mem_wdata    = (mem_rdata & ~plane_mask_c) | (fill_r & plane_mask_c);
    mem_re       = 1'b0;
    mem_raddr    = word_c[ADDR_W-1:0];
    finish_c     = 1'b0;
    res_color_c  = '0;
    res_drop_c   = drop_r;

    case (state_r)
      S_IDLE: begin
        if (in_take_c) begin
          idx_nxt      = IDX_W'(in_chan.pos_y) * ROW_STEP + IDX_W'(in_chan.pos_x);
          row_base_nxt = IDX_W'(in_chan.pos_y) * ROW_STEP + IDX_W'(in_chan.pos_x);
          fill_nxt     = pfde_pkg::spread_color(in_chan.color);
          drop_nxt     = 1'b0;
          waddr_nxt    = '0;
          res_nxt      = '0;
          case (pfde_pkg::cmd_kind_t'(in_chan.kind))
            pfde_pkg::KIND_PIXEL: begin
              rem_x_nxt = pfde_pkg::RW_W'(1);
              rem_y_nxt = pfde_pkg::RH_W'(1);
              rw_nxt    = pfde_pkg::RW_W'(1);
              state_nxt = S_FILL_RD;
            end
            pfde_pkg::KIND_FILL: begin
              rem_x_nxt = in_chan.rect_width;
              rem_y_nxt = in_chan.rect_height;
              rw_nxt    = in_chan.rect_width;
              if ((in_chan.rect_width == '0) || (in_chan.rect_height == '0)) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FILL_RD;
              end
            end
            pfde_pkg::KIND_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            pfde_pkg::KIND_READ: begin
              state_nxt = S_READ_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_FILL_RD: begin
        if (beyond_c) begin
          // The rest of this row lies past the store. A rectangle wider than the
          // screen can still bring the next row back inside, so the command ends here
          // only on its last row or when the next row starts past the store.
          drop_nxt = 1'b1;
          if ((rem_y_r == pfde_pkg::RH_W'(1)) || (next_row_c >= PIX_CNT)) begin
            finish_c   = 1'b1;
            res_drop_c = 1'b1;
          end else begin
            rem_y_nxt    = rem_y_r - pfde_pkg::RH_W'(1);
            row_base_nxt = next_row_c;
            idx_nxt      = next_row_c;
            rem_x_nxt    = rw_r;
          end
        end else begin
          mem_re    = 1'b1;
          mask_nxt  = run_mask_c & valid_mask_c;
          waddr_nxt = word_c[ADDR_W-1:0];
          last_nxt  = row_end_c && (rem_y_r == pfde_pkg::RH_W'(1));
          if ((run_mask_c & ~valid_mask_c) != 8'h00) begin
            drop_nxt = 1'b1;
          end
          // Step to the next run, or to the start of the next row.
          if (row_end_c) begin
            rem_y_nxt    = rem_y_r - pfde_pkg::RH_W'(1);
            row_base_nxt = next_row_c;
            idx_nxt      = next_row_c;
            rem_x_nxt    = rw_r;
          end else begin
            idx_nxt   = idx_r + IDX_W'(run_c);
            rem_x_nxt = rem_x_r - pfde_pkg::RW_W'(run_c);
          end
          state_nxt = S_FILL_WR;
        end
      end

      S_FILL_WR: begin
        mem_we = 1'b1;
        if (last_r) begin
          finish_c = 1'b1;
        end else begin
          state_nxt = S_FILL_RD;
        end
      end

      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = fill_r;
        if (waddr_r == LAST_ADDR) begin
          finish_c = 1'b1;
        end else begin
          waddr_nxt = waddr_r + ADDR_W'(1);
        end
      end

      S_READ_RD: begin
        if (beyond_c) begin
          finish_c   = 1'b1;
          res_drop_c = 1'b1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_READ_DATA;
        end
      end

      S_READ_DATA: begin
        finish_c    = 1'b1;
        res_color_c = rd_color_c;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A finished command hands its result over at once or parks in the done state.
    if (finish_c) begin
      res_nxt.read_color = res_color_c;
      res_nxt.dropped    = res_drop_c;
      state_nxt          = res_ready ? S_IDLE : S_DONE;
    end
  end

  // Result toward the output register.
  assign res_valid      = finish_c || (state_r == S_DONE);
  assign res.read_color = finish_c ? res_color_c : res_r.read_color;
  assign res.dropped    = finish_c ? res_drop_c : res_r.dropped;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    row_base_r <= row_base_nxt;
    rem_x_r    <= rem_x_nxt;
    rem_y_r    <= rem_y_nxt;
    rw_r       <= rw_nxt;
    fill_r     <= fill_nxt;
    mask_r     <= mask_nxt;
    waddr_r    <= waddr_nxt;
    last_r     <= last_nxt;
    drop_r     <= drop_nxt;
    res_r      <= res_nxt;
  end

endmodule

// ===== hdl/planar_framebuffer_draw_engine_top.sv =====
// Top level of the planar frame buffer draw engine: the sequencer, the plane store
// and the result register. Depends on pfde_pkg, pfde_if, pfde_ram and pfde_engine.
`timescale 1ns / 1ps

// The block keeps a 16-color screen in four bit planes, one 32-bit store word per
// eight pixels, and runs one command at a time; commands are taken only while the
// sequencer is idle, and a finished result waits in its own output register so the
// next command can start at once. The store sits in a single RAM with one read and
// one write port and a registered read; a pixel write or fill changes a word by a
// read followed by a write of the same word, and a clear only writes. A pixel that
// lies past the end of the store is dropped without a store access. A fill works
// through each rectangle row one store word at a time; it stops after the first row
// that reaches past the end of the store whose next row would start past the end.
// An empty fill touches no store word. A clear writes one word per cycle over all
// (SCREEN_WIDTH*SCREEN_HEIGHT+7)/8 store words. After reset the store content is
// undefined until a clear or write has set it; there is no clearing pass.
module planar_framebuffer_draw_engine_top #(
  parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  pfde_in_if.sink     in_chan,
  pfde_out_if.source  out_chan
);

  localparam int DEPTH  = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
  localparam int ADDR_W = pfde_pkg::addr_bits(DEPTH);

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [pfde_pkg::DATA_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [pfde_pkg::DATA_W-1:0] mem_rdata;
  logic                        res_valid;
  logic                        res_ready;
  pfde_pkg::res_t              res;

  logic                        out_valid_r, out_valid_nxt;
  pfde_pkg::res_t              out_res_r, out_res_nxt;

  // Plane store.
  pfde_ram #(
    .WIDTH  (pfde_pkg::DATA_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Command sequencer.
  pfde_engine #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (ADDR_W)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: loads when empty or when its content is taken this cycle.
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.read_color = out_res_r.read_color;
  assign out_chan.dropped    = out_res_r.dropped;

endmodule

// ===== hdl/pfde_checker.sv =====
// Port-level checker of the draw engine, bound to the top level.
// Depends on pfde_pkg and on the ports of planar_framebuffer_draw_engine_top.
`timescale 1ns / 1ps

module pfde_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pfde_pkg::COLOR_W-1:0] out_read_color,
  input logic                         out_dropped
);

  logic [1:0] pending_r, pending_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Commands taken whose result has not been transferred yet.
  always_comb begin
    pending_nxt = pending_r;
    if (in_xfer && !out_xfer) begin
      pending_nxt = pending_r + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pending_nxt = pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_color) && $stable(out_dropped))
    else $error("result changed while stalled");

  // A dropped pixel never reports a color.
  a_drop_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_read_color == '0)
    else $error("dropped result carries a color");

  // No result without a command behind it.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without a pending command");

  // At most one command in work and one result waiting.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> pending_r != 2'd2 && pending_r != 2'd3)
    else $error("command taken while two are outstanding");

endmodule

bind planar_framebuffer_draw_engine_top pfde_checker u_pfde_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_read_color (out_chan.read_color),
  .out_dropped    (out_chan.dropped)
);
